@@ hw/rtl/substring_first_match_search_unit_defines.svh @@
// ============================================================================
// Substring search unit assertion macros
// Shared property forms for the port checker of the search unit.
// ============================================================================
`ifndef SUBSTRING_FIRST_MATCH_SEARCH_UNIT_DEFINES_SVH
`define SUBSTRING_FIRST_MATCH_SEARCH_UNIT_DEFINES_SVH

// Check a consequence in the same cycle as its cause
`define SFMS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause
`define SFMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/sfms_pkg.sv @@
// ============================================================================
// Substring search package
// Types, widths, register indexes and pattern helpers of the search unit.
// ============================================================================
package sfms_pkg;

    localparam int BYTE_W        = 8;
    localparam int CFG_W         = 64;
    localparam int CFG_IDX_W     = 2;
    localparam int LEN_W         = 5;
    localparam int MPOS_W        = 16;
    localparam int PATTERN_BYTES = 16;
    localparam int PATTERN_W     = PATTERN_BYTES * BYTE_W;
    localparam int QUEUE_DEPTH   = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW  = 2'd0,
        CFG_PATTERN_HIGH = 2'd1,
        CFG_PATTERN_LEN  = 2'd2,
        CFG_SEARCH_START = 2'd3
    } t_sfms_cfg_index;

    // Input request
    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              last_byte;
    } t_sfms_in;

    // Result request
    typedef struct packed {
        logic              found;
        logic [MPOS_W-1:0] match_position;
        logic              text_too_long;
    } t_sfms_out;

    // Classified byte handed from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              last_byte;
        logic              beyond_limit;
    } t_sfms_task;

    // Pattern byte k; bytes past the pattern registers read as zero
    function automatic logic [BYTE_W-1:0] pattern_byte(
        input logic [PATTERN_W-1:0] pattern,
        input logic [LEN_W-1:0]     k
    );
        logic [BYTE_W-1:0] b;
        b = '0;
        if (int'(k) < PATTERN_BYTES) begin
            b = pattern[k[3:0]*BYTE_W +: BYTE_W];
        end
        return b;
    endfunction

endpackage

@@ hw/rtl/sfms_queue.sv @@
// ============================================================================
// Search unit task queue
// Small FIFO that decouples the classifying front from the compare back.
// ============================================================================
module sfms_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr, n_wr_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              w_push, w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Advance pointers with wrap
    always_comb begin
        n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    // Track fill and pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ hw/rtl/sfms_front.sv @@
// ============================================================================
// Search unit front end
// Accepts text bytes, numbers them and marks bytes past the position limit.
// ============================================================================
module sfms_front #(
    parameter int TEXT_POSITIONS = 65536,
    parameter int POS_W          = 17
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  sfms_pkg::t_sfms_in    i_in_data,
    input  logic                  i_queue_full,
    output logic                  o_push,
    output sfms_pkg::t_sfms_task  o_task,
    output logic [POS_W-1:0]      o_end_pos
);
    import sfms_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic             w_accept, w_in_range;

    assign o_in_stall = i_queue_full;
    assign w_accept   = i_in_valid && !i_queue_full;
    assign o_push     = w_accept;
    assign w_in_range = (r_pos < POS_W'(TEXT_POSITIONS));

    // Classify the byte and give its end position
    always_comb begin
        o_task.text_byte    = i_in_data.text_byte;
        o_task.last_byte    = i_in_data.last_byte;
        o_task.beyond_limit = !w_in_range;
        o_end_pos           = r_pos + 1'b1;
    end

    // Count stored bytes; restart at the end of a text
    always_comb begin
        n_pos = r_pos;
        if (w_accept) begin
            if (i_in_data.last_byte) begin
                n_pos = '0;
            end else if (w_in_range) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

@@ hw/rtl/sfms_back.sv @@
// ============================================================================
// Search unit back end
// Shifts bytes into the window, compares the pattern, latches the first match
// and holds the result in an output register.
// ============================================================================
module sfms_back #(
    parameter int PATTERN_MAX = 16,
    parameter int POS_W       = 17
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_queue_valid,
    input  sfms_pkg::t_sfms_task              i_task,
    input  logic [POS_W-1:0]                  i_end_pos,
    output logic                              o_pop,
    input  logic [sfms_pkg::PATTERN_W-1:0]    i_pattern,
    input  logic [sfms_pkg::LEN_W-1:0]        i_len,
    input  logic [sfms_pkg::MPOS_W-1:0]       i_search_start,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output sfms_pkg::t_sfms_out               o_out_data
);
    import sfms_pkg::*;

    localparam int CMP_W = (POS_W > MPOS_W) ? POS_W : MPOS_W;

    logic [BYTE_W-1:0] r_window [PATTERN_MAX];
    logic [BYTE_W-1:0] w_shift  [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] w_lane_ok;
    logic              r_latched, n_latched;
    logic [MPOS_W-1:0] r_first, n_first;
    logic              r_overflow, n_overflow;
    logic              r_out_valid;
    t_sfms_out         r_out_data, n_out_data;
    logic              w_out_free, w_pop, w_hit;
    logic [POS_W-1:0]  w_start;
    logic [CMP_W-1:0]  w_start_ext;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_pop       = i_queue_valid && (!i_task.last_byte || w_out_free);
    assign o_pop       = w_pop;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Compare each window lane with its pattern byte
    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_lane
        logic [LEN_W-1:0] w_k;
        if (j == 0) begin : g_head
            assign w_shift[j] = i_task.text_byte;
        end else begin : g_tail
            assign w_shift[j] = r_window[j-1];
        end
        assign w_k          = LEN_W'(int'(i_len) - 1 - j);
        assign w_lane_ok[j] = (int'(i_len) <= j) ||
                              (w_shift[j] == pattern_byte(i_pattern, w_k));
    end

    // Check start position and pattern hit for this byte
    assign w_start     = i_end_pos - POS_W'(i_len);
    assign w_start_ext = CMP_W'(w_start);
    assign w_hit = w_pop && !i_task.beyond_limit && !r_latched &&
                   (i_end_pos >= POS_W'(i_len)) &&
                   (w_start_ext >= CMP_W'(i_search_start)) && (&w_lane_ok);

    // Merge this byte into the per-text state and form the result
    always_comb begin
        n_latched  = r_latched || w_hit;
        n_first    = w_hit ? MPOS_W'(w_start_ext) : r_first;
        n_overflow = r_overflow || (w_pop && i_task.beyond_limit);
        n_out_data.found          = n_latched;
        n_out_data.match_position = n_latched ? n_first : '0;
        n_out_data.text_too_long  = n_overflow;
    end

    // Update text state; clear it after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latched  <= 1'b0;
            r_first    <= '0;
            r_overflow <= 1'b0;
            for (int i = 0; i < PATTERN_MAX; i++) begin
                r_window[i] <= '0;
            end
        end else if (w_pop) begin
            if (i_task.last_byte) begin
                r_latched  <= 1'b0;
                r_first    <= '0;
                r_overflow <= 1'b0;
                for (int i = 0; i < PATTERN_MAX; i++) begin
                    r_window[i] <= '0;
                end
            end else begin
                r_latched  <= n_latched;
                r_first    <= n_first;
                r_overflow <= n_overflow;
                if (!i_task.beyond_limit) begin
                    for (int i = 0; i < PATTERN_MAX; i++) begin
                        r_window[i] <= w_shift[i];
                    end
                end
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_pop && i_task.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && i_task.last_byte) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

@@ hw/rtl/substring_first_match_search_unit.sv @@
// ============================================================================
// Substring first-match search unit
// Streams a text one byte per request and reports where a configured pattern
// first occurs at or after a configured start position.
// ============================================================================
// The unit takes one text byte every cycle while the queue is not full, and
// returns one result request for the byte marked last. A byte passes an input
// counter in the front, waits in a two-entry queue, and is shifted into a
// window of PATTERN_MAX bytes in the back, where the whole pattern is compared
// against the window combinationally; that window compare sets the rate.
// The result is held in an output register that is written when the back
// pops the last byte. Stalls on the result side stop only the back after a
// last byte; the queue then fills and the input stalls. The user must write
// configuration only while no text is in flight; the unit does not enforce it.
module substring_first_match_search_unit #(
    parameter int PATTERN_MAX    = 16,
    parameter int TEXT_POSITIONS = 65536
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  sfms_pkg::t_sfms_in               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output sfms_pkg::t_sfms_out              o_out_data,
    input  logic                             i_cfg_we,
    input  logic [sfms_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sfms_pkg::CFG_W-1:0]       i_cfg_data
);
    import sfms_pkg::*;

    localparam int POS_W  = $clog2(TEXT_POSITIONS + 1);
    localparam int TASK_W = $bits(t_sfms_task);
    localparam int ITEM_W = TASK_W + POS_W;

    logic [CFG_W-1:0]  r_pat_low, r_pat_high;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [MPOS_W-1:0] r_search_start;
    logic [LEN_W-1:0]  w_len_raw;

    t_sfms_task        w_front_task, w_back_task;
    logic [POS_W-1:0]  w_front_end, w_back_end;
    logic              w_push, w_queue_full, w_queue_valid, w_pop;
    logic [ITEM_W-1:0] w_queue_out;

    // Clamp the pattern length to 1..PATTERN_MAX on write
    assign w_len_raw = i_cfg_data[LEN_W-1:0];
    always_comb begin
        n_len = w_len_raw;
        if (w_len_raw == '0) begin
            n_len = LEN_W'(1);
        end else if (int'(w_len_raw) > PATTERN_MAX) begin
            n_len = LEN_W'(PATTERN_MAX);
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low      <= '0;
            r_pat_high     <= '0;
            r_len          <= LEN_W'(1);
            r_search_start <= '0;
        end else if (i_cfg_we) begin
            case (t_sfms_cfg_index'(i_cfg_index))
                CFG_PATTERN_LOW:  begin
                    r_pat_low <= i_cfg_data;
                end
                CFG_PATTERN_HIGH: begin
                    r_pat_high <= i_cfg_data;
                end
                CFG_PATTERN_LEN:  begin
                    r_len <= n_len;
                end
                CFG_SEARCH_START: begin
                    r_search_start <= i_cfg_data[MPOS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    sfms_front #(
        .TEXT_POSITIONS (TEXT_POSITIONS),
        .POS_W          (POS_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_queue_full (w_queue_full),
        .o_push       (w_push),
        .o_task       (w_front_task),
        .o_end_pos    (w_front_end)
    );

    sfms_queue #(
        .DATA_W (ITEM_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_front_end, w_front_task}),
        .o_full  (w_queue_full),
        .i_pop   (w_pop),
        .o_valid (w_queue_valid),
        .o_data  (w_queue_out)
    );

    assign w_back_task = t_sfms_task'(w_queue_out[TASK_W-1:0]);
    assign w_back_end  = w_queue_out[ITEM_W-1:TASK_W];

    sfms_back #(
        .PATTERN_MAX (PATTERN_MAX),
        .POS_W       (POS_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_queue_valid  (w_queue_valid),
        .i_task         (w_back_task),
        .i_end_pos      (w_back_end),
        .o_pop          (w_pop),
        .i_pattern      ({r_pat_high, r_pat_low}),
        .i_len          (r_len),
        .i_search_start (r_search_start),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_data     (o_out_data)
    );

endmodule

@@ hw/rtl/sfms_checker.sv @@
// ============================================================================
// Search unit port checker
// Watches the ports of the search unit for result and flow-control slips.
// ============================================================================
`include "substring_first_match_search_unit_defines.svh"

module sfms_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 o_in_stall,
    input  logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  sfms_pkg::t_sfms_out  o_out_data
);
    import sfms_pkg::*;

    // Stalled result holds
    `SFMS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_data), "stalled result changed")

    // No match reports position zero
    `SFMS_ASSERT_NOW(a_pos_zero, o_out_valid && !o_out_data.found,
        o_out_data.match_position == '0, "position set without a match")

    // Leave reset with no result pending
    `SFMS_ASSERT_NOW(a_reset_idle, $past(!i_rst_n), !o_out_valid,
        "result pending right after reset")

    // Queue drains while the result side is free
    `SFMS_ASSERT_NEXT(a_stall_free, o_in_stall && !o_out_valid, !o_in_stall,
        "input stalled with idle result side")

endmodule

bind substring_first_match_search_unit sfms_checker u_sfms_checker (.*);
